>>> design/rmv_pkg.sv
// Shared constants, types and command and status structs for the running statistics block.
`timescale 1ns / 1ps

package rmv_pkg;

   // Sample width actually used and fraction bits of the fixed-point mean.
   localparam int SAMPLE_BITS       = 32;
   localparam int FRAC_BITS         = 16;

   // Field widths at the channel boundary.
   localparam int SAMPLE_FIELD_BITS = 32;
   localparam int COUNT_BITS        = 32;
   localparam int MEAN_BITS         = 48;
   localparam int VAR_BITS          = 63;
   localparam int DEV_BITS          = 64;

   // Scaled sample, signed difference to the mean, and the full product.
   localparam int XF_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int DELTA_BITS = ((XF_BITS > MEAN_BITS) ? XF_BITS : MEAN_BITS) + 1;
   localparam int PROD_BITS  = 2 * DELTA_BITS;

   // Divider dividend/quotient width and the step counter that walks it.
   localparam int DIV_BITS   = DEV_BITS;
   localparam int STEP_BITS  = $clog2(DIV_BITS);

   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MEAN_UPD,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_ACC_UPD,
      ST_VAR_LOAD,
      ST_DIV_VAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic start_add;
      logic div_step;
      logic mean_upd;
      logic mul_load;
      logic mul_step;
      logic acc_upd;
      logic var_load;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic var_needed;
   } status_type;

endpackage

>>> design/rmv_if.sv
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps

interface rmv_req_if import rmv_pkg::*; ();
   logic                                valid;
   logic                                ready;
   op_type                              operation;
   logic signed [SAMPLE_FIELD_BITS-1:0] sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

interface rmv_rsp_if import rmv_pkg::*; ();
   logic                                valid;
   logic                                ready;
   logic        [COUNT_BITS-1:0]        count;
   logic signed [MEAN_BITS-1:0]         mean_value;
   logic        [VAR_BITS-1:0]          variance;
   logic signed [SAMPLE_FIELD_BITS-1:0] minimum;
   logic signed [SAMPLE_FIELD_BITS-1:0] maximum;
   logic                                has_data;

   modport source (output valid, output count, output mean_value, output variance,
                   output minimum, output maximum, output has_data, input ready);
   modport sink   (input valid, input count, input mean_value, input variance,
                   input minimum, input maximum, input has_data, output ready);
endinterface

>>> design/running_mean_variance_minmax.sv
// Top level of the running mean / variance / min / max statistics block.
`timescale 1ns / 1ps

// Welford running statistics over signed samples. Each request transaction
// either adds one sample (operation 0) or clears everything (operation 1), and
// each one produces exactly one response transaction carrying the sample count
// (saturating), the mean in signed fixed point with FRAC_BITS fraction bits,
// the sample variance (deviation sum over count minus one, same fixed point,
// zero below two samples, saturating), the minimum, the maximum and a has_data
// flag. Items are processed one at a time. An add makes two passes through
// the one-bit-per-cycle restoring divider (mean update, then variance) and
// one pass through the one-bit-per-cycle shift-add multiplier for the
// squared-deviation term; with fewer than two samples the variance division
// is skipped. A clear goes straight from idle to the finish state. The
// response sits in an output register, so the next request is taken while an
// earlier response is still waiting on rsp_bus.ready.
module running_mean_variance_minmax import rmv_pkg::*; (
   input logic     clock,
   input logic     reset,
   rmv_req_if.sink   req_bus,
   rmv_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   // sequencer: handshakes and step control
   rmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.operation),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, statistics state and response payload register
   rmv_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_bus.sample),
      .rsp_count      (rsp_bus.count),
      .rsp_mean_value (rsp_bus.mean_value),
      .rsp_variance   (rsp_bus.variance),
      .rsp_minimum    (rsp_bus.minimum),
      .rsp_maximum    (rsp_bus.maximum),
      .rsp_has_data   (rsp_bus.has_data)
   );

endmodule

>>> design/rmv_ctrl.sv
// Sequencer: walks an add through divide, multiply, accumulate and, with two or more samples, divide.
`timescale 1ns / 1ps

module rmv_ctrl import rmv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  cmd.start_add = 1'b1;
                  step_in       = STEP_BITS'(DIV_BITS - 1);
                  state_in      = ST_DIV_MEAN;
               end
            end
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) state_in = ST_MEAN_UPD;
            else               step_in  = step_ff - 1'b1;
         end
         ST_MEAN_UPD: begin
            cmd.mean_upd = 1'b1;
            state_in     = ST_MUL_LOAD;
         end
         ST_MUL_LOAD: begin
            cmd.mul_load = 1'b1;
            step_in      = STEP_BITS'(DELTA_BITS - 1);
            state_in     = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            if (step_ff == '0) state_in = ST_ACC_UPD;
            else               step_in  = step_ff - 1'b1;
         end
         ST_ACC_UPD: begin
            cmd.acc_upd = 1'b1;
            if (status.var_needed) state_in = ST_VAR_LOAD;
            else                   state_in = ST_FINISH;
         end
         ST_VAR_LOAD: begin
            cmd.var_load = 1'b1;
            step_in      = STEP_BITS'(DIV_BITS - 1);
            state_in     = ST_DIV_VAR;
         end
         ST_DIV_VAR: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) state_in = ST_FINISH;
            else               step_in  = step_ff - 1'b1;
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_clear_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_op == OP_CLEAR) |=> state_ff == ST_FINISH)
      else $error("clear transaction did not go straight to finish");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_op == OP_ADD)
         |=> ##(DIV_BITS) state_ff == ST_MEAN_UPD)
      else $error("mean division did not take the full step count");

   a_hold_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_FINISH)
      else $error("pending response overwritten");
`endif

endmodule

>>> design/rmv_dp.sv
// Datapath: statistics registers, shared radix-2 divider, shift-add multiplier.
`timescale 1ns / 1ps

module rmv_dp import rmv_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  cmd_type                             cmd,
   output status_type                          status,
   input  logic signed [SAMPLE_FIELD_BITS-1:0] req_sample,
   output logic        [COUNT_BITS-1:0]        rsp_count,
   output logic signed [MEAN_BITS-1:0]         rsp_mean_value,
   output logic        [VAR_BITS-1:0]          rsp_variance,
   output logic signed [SAMPLE_FIELD_BITS-1:0] rsp_minimum,
   output logic signed [SAMPLE_FIELD_BITS-1:0] rsp_maximum,
   output logic                                rsp_has_data
);

   // statistics state
   logic        [COUNT_BITS-1:0]  count_ff;
   logic signed [MEAN_BITS-1:0]   mean_ff;
   logic        [DEV_BITS-1:0]    dev_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff, max_ff;

   // per-transaction working registers
   logic signed [DELTA_BITS-1:0]  xf_ff;
   logic                          delta_neg_ff;
   logic        [DELTA_BITS-1:0]  delta_mag_ff;
   logic        [COUNT_BITS:0]    div_rem_ff;
   logic        [DIV_BITS-1:0]    div_quo_ff;
   logic        [COUNT_BITS-1:0]  div_den_ff;
   logic        [DELTA_BITS-1:0]  mul_a_ff;
   logic        [PROD_BITS-1:0]   mul_prod_ff;

   // output register
   logic        [COUNT_BITS-1:0]        out_count_ff;
   logic signed [MEAN_BITS-1:0]         out_mean_ff;
   logic        [VAR_BITS-1:0]          out_var_ff;
   logic signed [SAMPLE_FIELD_BITS-1:0] out_min_ff, out_max_ff;
   logic                                out_has_data_ff;

   logic signed [SAMPLE_BITS-1:0] sample_s;
   logic signed [DELTA_BITS-1:0]  xf_new, xf_src, mean_ext, diff_pos, diff_rev;
   logic                          diff_neg;
   logic        [DELTA_BITS-1:0]  diff_mag;
   logic        [COUNT_BITS-1:0]  count_next;
   logic        [COUNT_BITS:0]    div_shift;
   logic        [COUNT_BITS+1:0]  div_diff;
   logic        [DELTA_BITS:0]    mean_addend, mean_sum;
   logic        [DELTA_BITS-MEAN_BITS+1:0] mean_hi;
   logic signed [MEAN_BITS-1:0]   mean_sat;
   logic        [DELTA_BITS:0]    mul_sum;
   logic        [DEV_BITS-1:0]    acc_add;
   logic        [DEV_BITS:0]      acc_sum;
   logic        [VAR_BITS-1:0]    var_val;

   assign sample_s = req_sample[SAMPLE_BITS-1:0];
   assign xf_new   = DELTA_BITS'(sample_s) <<< FRAC_BITS;
   assign mean_ext = DELTA_BITS'(mean_ff);

   // one subtractor pair serves both delta (old mean) and the post-update difference
   assign xf_src   = cmd.start_add ? xf_new : xf_ff;
   assign diff_pos = xf_src - mean_ext;
   assign diff_rev = mean_ext - xf_src;
   assign diff_neg = diff_pos[DELTA_BITS-1];
   assign diff_mag = diff_neg ? diff_rev : diff_pos;

   assign count_next = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   // restoring division step
   assign div_shift = {div_rem_ff[COUNT_BITS-1:0], div_quo_ff[DIV_BITS-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, div_den_ff};

   // mean plus signed quotient, saturated to the mean range
   always_comb begin
      mean_addend = delta_neg_ff ? ~{1'b0, div_quo_ff[DELTA_BITS-1:0]}
                                 :  {1'b0, div_quo_ff[DELTA_BITS-1:0]};
      mean_sum    = (DELTA_BITS+1)'(mean_ff) + mean_addend
                    + (DELTA_BITS+1)'(delta_neg_ff);
      mean_hi     = mean_sum[DELTA_BITS:MEAN_BITS-1];
      if (mean_hi == '0 || mean_hi == '1)
         mean_sat = mean_sum[MEAN_BITS-1:0];
      else if (mean_sum[DELTA_BITS])
         mean_sat = {1'b1, {(MEAN_BITS-1){1'b0}}};
      else
         mean_sat = {1'b0, {(MEAN_BITS-1){1'b1}}};
   end

   assign mul_sum = {1'b0, mul_prod_ff[PROD_BITS-1:DELTA_BITS]} + {1'b0, mul_a_ff};

   // shifted product, saturated, then a saturating accumulate
   assign acc_add = (mul_prod_ff[PROD_BITS-1:FRAC_BITS+DEV_BITS] != '0) ? '1
                    : mul_prod_ff[FRAC_BITS+DEV_BITS-1:FRAC_BITS];
   assign acc_sum = {1'b0, dev_ff} + {1'b0, acc_add};

   assign status.var_needed = (count_ff > COUNT_BITS'(1));

   assign var_val = !status.var_needed ? '0
                    : (div_quo_ff[DIV_BITS-1:VAR_BITS] != '0) ? '1
                    : div_quo_ff[VAR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         mean_ff  <= '0;
         dev_ff   <= '0;
         min_ff   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         max_ff   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         if (cmd.start_add) begin
            count_ff <= count_next;
            if (sample_s < min_ff) min_ff <= sample_s;
            if (sample_s > max_ff) max_ff <= sample_s;
         end
         if (cmd.mean_upd) mean_ff <= mean_sat;
         if (cmd.acc_upd)  dev_ff  <= acc_sum[DEV_BITS] ? '1 : acc_sum[DEV_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_add) begin
         xf_ff        <= xf_new;
         delta_neg_ff <= diff_neg;
         delta_mag_ff <= diff_mag;
         div_rem_ff   <= '0;
         div_quo_ff   <= DIV_BITS'(diff_mag);
         div_den_ff   <= count_next;
      end else if (cmd.var_load) begin
         div_rem_ff   <= '0;
         div_quo_ff   <= dev_ff;
         div_den_ff   <= count_ff - 1'b1;
      end else if (cmd.div_step) begin
         div_rem_ff   <= div_diff[COUNT_BITS+1] ? div_shift : div_diff[COUNT_BITS:0];
         div_quo_ff   <= {div_quo_ff[DIV_BITS-2:0], !div_diff[COUNT_BITS+1]};
      end

      if (cmd.mul_load) begin
         mul_a_ff    <= delta_mag_ff;
         mul_prod_ff <= {{DELTA_BITS{1'b0}}, diff_mag};
      end else if (cmd.mul_step) begin
         if (mul_prod_ff[0])
            mul_prod_ff <= {mul_sum, mul_prod_ff[DELTA_BITS-1:1]};
         else
            mul_prod_ff <= {1'b0, mul_prod_ff[PROD_BITS-1:1]};
      end

      if (cmd.load_out) begin
         out_count_ff    <= count_ff;
         out_mean_ff     <= mean_ff;
         out_var_ff      <= var_val;
         out_min_ff      <= SAMPLE_FIELD_BITS'(min_ff);
         out_max_ff      <= SAMPLE_FIELD_BITS'(max_ff);
         out_has_data_ff <= (count_ff != '0);
      end
   end

   assign rsp_count      = out_count_ff;
   assign rsp_mean_value = out_mean_ff;
   assign rsp_variance   = out_var_ff;
   assign rsp_minimum    = out_min_ff;
   assign rsp_maximum    = out_max_ff;
   assign rsp_has_data   = out_has_data_ff;

`ifndef ASSERT_OFF
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum above maximum with samples present");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      !cmd.clear |=> (count_ff >= $past(count_ff)))
      else $error("sample count went down without a clear");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (div_den_ff != '0))
      else $error("divider running with zero divisor");
`endif

endmodule
